// ===== rtl/lrumc_pkg.sv =====
// lrumc_pkg: shared types and fixed constants of the lru cache miss counter
// used by lrumc_cell and lru_cache_miss_counter; depends on nothing
package lrumc_pkg;

    // capacity register
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // miss counter
    localparam int MISS_W = 32;
    localparam logic [MISS_W-1:0] MISS_MAX = {MISS_W{1'b1}};

    // per-access control broadcast to every cell
    typedef struct packed {
        logic access;   // an item is accepted this cycle
        logic miss;     // the key matched no valid cell
        logic evict;    // miss with the store full, the insert position is dropped
    } cell_ctrl_t;

endpackage

// ===== rtl/lrumc_cell.sv =====
// lrumc_cell: one recency position of the lru chain, holding one key
// depends on lrumc_pkg; instantiated in a row by lru_cache_miss_counter
module lrumc_cell
    import lrumc_pkg::*;
#(
    parameter int KEY_BITS = 16,
    parameter int OCC_W    = 5,
    parameter int IDX      = 0
)
(
    input  logic                clk,
    input  cell_ctrl_t          ctrl,
    input  logic [OCC_W-1:0]    occ,
    input  logic [OCC_W-1:0]    ins_pos,
    input  logic [KEY_BITS-1:0] lookup_key,
    input  logic [KEY_BITS-1:0] shift_in,
    input  logic                load_in,
    input  logic [KEY_BITS-1:0] ev_in,
    output logic                match,
    output logic [KEY_BITS-1:0] key_out,
    output logic                load_out,
    output logic [KEY_BITS-1:0] ev_out
);

    localparam logic [OCC_W-1:0] POS = OCC_W'(IDX);

    logic [KEY_BITS-1:0] key_reg;
    logic                live;
    logic                target;

    // a position holds a live entry while it lies below the occupancy
    assign live  = (POS < occ);
    assign match = live && (key_reg == lookup_key);

    // the position that leaves the chain: the hit entry, or the insert point on a miss
    assign target = ctrl.miss ? (POS == ins_pos) : match;

    // every position from zero up to the target takes its neighbor's key
    assign load_out = target | load_in;

    // evicted key rides down the chain; this cell adds its key only when it is dropped
    assign ev_out = ev_in | ((ctrl.evict && target) ? key_reg : '0);

    assign key_out = key_reg;

    // key storage
    always_ff @(posedge clk)
    begin
        if (ctrl.access && load_out)
        begin
            key_reg <= shift_in;
        end
    end

endmodule

// ===== rtl/lru_cache_miss_counter.sv =====
// lru_cache_miss_counter: fully associative lru key store with a saturating miss count
// depends on lrumc_pkg and lrumc_cell
//
//   channel   direction  signals                                   handshake
//   input     in         key, restart                              in_valid / in_stall
//   result    out        hit, evicted_valid, evicted_key,          out_valid / out_stall
//                        miss_count
//   config    in         cfg_wr_data (capacity)                    cfg_wr_en
//
// one item per cycle while in_stall is low; an item's lookup, reorder and count update finish in the
// cycle it is accepted, the path being the key compare and the load chain
// through the row of ENTRIES cells. the result is registered when the item is accepted.
// reset empties the store (occupancy zero), clears the count and sets capacity to 16.
// in_stall is high only while a result is held and out_stall is high.
module lru_cache_miss_counter
    import lrumc_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CAP_W-1:0]    cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [KEY_BITS-1:0] key,
    input  logic                restart,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                hit,
    output logic                evicted_valid,
    output logic [KEY_BITS-1:0] evicted_key,
    output logic [MISS_W-1:0]   miss_count
);

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [CW-1:0]    ENTRIES_CW  = CW'(ENTRIES);
    localparam logic [OCC_W-1:0] ENTRIES_OCC = OCC_W'(ENTRIES);

    logic [CAP_W-1:0]    capacity_reg;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;
    logic [MISS_W-1:0]   misses_reg;
    logic [MISS_W-1:0]   misses_next;
    logic                out_valid_reg;
    logic                hit_reg;
    logic                ev_valid_reg;
    logic [KEY_BITS-1:0] ev_key_reg;

    logic                accept;
    logic [OCC_W-1:0]    occ_eff;
    logic [MISS_W-1:0]   misses_eff;
    logic [CW-1:0]       cap_ext;
    logic [CW-1:0]       cap_eff;
    logic                full;
    logic                hit_any;
    logic [OCC_W-1:0]    ins_pos;
    cell_ctrl_t          ctrl;

    logic [ENTRIES-1:0]  match_vec;
    logic [KEY_BITS-1:0] cell_key [ENTRIES];
    logic [KEY_BITS-1:0] shift_data [ENTRIES];
    logic                load_chain [ENTRIES+1];
    logic [KEY_BITS-1:0] ev_chain [ENTRIES+1];

    // handshake
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // restart empties the store and clears the miss count before the lookup
    assign occ_eff    = restart ? '0 : occ_reg;
    assign misses_eff = restart ? '0 : misses_reg;

    // effective capacity, clamped to one .. ENTRIES
    assign cap_ext = CW'(capacity_reg);
    always_comb
    begin
        if (cap_ext == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (cap_ext > ENTRIES_CW)
        begin
            cap_eff = ENTRIES_CW;
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    // lookup outcome and insert position
    assign hit_any = |match_vec;
    assign full    = (CW'(occ_eff) >= cap_eff);
    assign ins_pos = full ? (occ_eff - OCC_W'(1)) : occ_eff;

    assign ctrl.access = accept;
    assign ctrl.miss   = ~hit_any;
    assign ctrl.evict  = ~hit_any & full;

    // occupancy and saturating miss count after this item
    assign occ_next    = (~hit_any && !full) ? (occ_eff + OCC_W'(1)) : occ_eff;
    assign misses_next = (~hit_any && misses_eff != MISS_MAX) ? (misses_eff + MISS_W'(1))
                                                             : misses_eff;

    // chain ends
    assign load_chain[ENTRIES] = 1'b0;
    assign ev_chain[0]         = '0;

    // row of cells, most recent at position zero
    for (genvar j = 0; j < ENTRIES; j++)
    begin : g_cell
        if (j == 0)
        begin : g_head
            assign shift_data[j] = key;
        end
        else
        begin : g_body
            assign shift_data[j] = cell_key[j-1];
        end

        lrumc_cell #(
            .KEY_BITS (KEY_BITS),
            .OCC_W    (OCC_W),
            .IDX      (j)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occ        (occ_eff),
            .ins_pos    (ins_pos),
            .lookup_key (key),
            .shift_in   (shift_data[j]),
            .load_in    (load_chain[j+1]),
            .ev_in      (ev_chain[j]),
            .match      (match_vec[j]),
            .key_out    (cell_key[j]),
            .load_out   (load_chain[j]),
            .ev_out     (ev_chain[j+1])
        );
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            occ_reg       <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                occ_reg       <= occ_next;
                misses_reg    <= misses_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg      <= hit_any;
            ev_valid_reg <= ctrl.evict;
            ev_key_reg   <= ev_chain[ENTRIES];
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_key   = ev_key_reg;
    assign miss_count    = misses_reg;

    // occupancy never runs past the row
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= ENTRIES_OCC)
        else $error("occupancy beyond entry count");

    // keys in live cells are unique
    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> $onehot0(match_vec))
        else $error("key matched more than one cell");

    // an eviction is always a miss
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ev_valid_reg |-> !hit_reg)
        else $error("eviction reported on a hit");

    // every accepted item leaves at least one entry live
    a_occ_live: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> occ_reg != '0)
        else $error("store empty after an access");

    // a held result keeps its count
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> $stable(miss_count))
        else $error("miss count moved under a stall");

endmodule
